// ----- hw/rtl/xmodem_checksum_receiver_unit_defines.svh -----
// Assertion macros for the receiver RTL; xcr_core is the file that includes them.
`ifndef XMODEM_CHECKSUM_RECEIVER_UNIT_DEFINES_SVH
`define XMODEM_CHECKSUM_RECEIVER_UNIT_DEFINES_SVH

`ifndef SYNTH
// Checked on every clock edge outside reset.
`define XCR_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("xcr assertion failed");
// Checked on every clock edge, reset included.
`define XCR_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("xcr assertion failed");
`else
`define XCR_ASSERT(label, prop)
`define XCR_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ----- hw/rtl/xcr_pkg.sv -----
// Types and constants shared by the XMODEM checksum receiver.
package xcr_pkg;

    localparam int PAYLOAD_BYTES_DEF = 128;

    // Reset values of the configuration registers.
    localparam logic [15:0] TIMEOUT_TICKS_RST  = 16'd1000;
    localparam logic [7:0]  START_RETRIES_RST  = 8'd60;
    localparam logic [7:0]  PACKET_RETRIES_RST = 8'd10;
    localparam logic [7:0]  MAX_FAILURES_RST   = 8'd10;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_TIMEOUT_TICKS  = 2'd0;
    localparam logic [1:0] REG_START_RETRIES  = 2'd1;
    localparam logic [1:0] REG_PACKET_RETRIES = 2'd2;
    localparam logic [1:0] REG_MAX_FAILURES   = 2'd3;

    // Input commands.
    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_REPLY   = 2'd2;

    // Protocol bytes.
    localparam logic [7:0] BYTE_SOH = 8'h01;
    localparam logic [7:0] BYTE_EOT = 8'h04;
    localparam logic [7:0] BYTE_ACK = 8'h06;
    localparam logic [7:0] BYTE_NAK = 8'h15;
    localparam logic [7:0] BYTE_CAN = 8'h18;

    localparam logic [7:0] FAIL_SAT = 8'hFF;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       commit;
        logic       session_end;
        logic       handled;
        logic       active;
    } t_out_item;

    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [7:0]  start_retries;
        logic [7:0]  packet_retries;
        logic [7:0]  max_failures;
    } t_cfg;

endpackage

// ----- hw/rtl/xmodem_checksum_receiver_unit.sv -----
// XMODEM checksum receiver, top level: transfer registers around the protocol core.
// Every accepted item (received byte, timer tick or session start) yields exactly one
// result: the item waits in the input register, then the protocol state update and
// result are formed in a single pass and land in the result register once it is free.
// A new item is taken every cycle while results are being taken; the rate is
// set by that one-pass state update in xcr_core. Configuration is on the APB port at
// byte addresses 0, 4, 8 and 12 and should be written only while no item is in flight.
module xmodem_checksum_receiver_unit
    import xcr_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic      advance;
    t_cfg      cfg;
    t_out_item result;

    // The held item moves into the result register whenever that register is free
    // or is being emptied by a transfer in the same cycle.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= result;
        end
    end

    xcr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    xcr_core #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- hw/rtl/xcr_regs.sv -----
// APB configuration registers of the XMODEM checksum receiver.
module xcr_regs
    import xcr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_ticks  <= TIMEOUT_TICKS_RST;
            r_cfg.start_retries  <= START_RETRIES_RST;
            r_cfg.packet_retries <= PACKET_RETRIES_RST;
            r_cfg.max_failures   <= MAX_FAILURES_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_TIMEOUT_TICKS:  r_cfg.timeout_ticks  <= pwdata[15:0];
                REG_START_RETRIES:  r_cfg.start_retries  <= pwdata[7:0];
                REG_PACKET_RETRIES: r_cfg.packet_retries <= pwdata[7:0];
                REG_MAX_FAILURES:   r_cfg.max_failures   <= pwdata[7:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_TIMEOUT_TICKS:  prdata = {16'd0, r_cfg.timeout_ticks};
            REG_START_RETRIES:  prdata = {24'd0, r_cfg.start_retries};
            REG_PACKET_RETRIES: prdata = {24'd0, r_cfg.packet_retries};
            REG_MAX_FAILURES:   prdata = {24'd0, r_cfg.max_failures};
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hw/rtl/xcr_core.sv -----
// Session, framing and timeout state of the receiver with its per-item update.
`include "xmodem_checksum_receiver_unit_defines.svh"

module xcr_core
    import xcr_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    localparam int POS_W = $clog2(PAYLOAD_BYTES + 3);
    localparam logic [POS_W-1:0] POS_CHECKSUM = POS_W'(PAYLOAD_BYTES + 2);

    logic             r_session_on,     n_session_on;
    logic             r_in_packet,      n_in_packet;
    logic [POS_W-1:0] r_byte_pos,       n_byte_pos;
    logic [7:0]       r_expected_block, n_expected_block;
    logic [7:0]       r_block_seen,     n_block_seen;
    logic [7:0]       r_running_sum,    n_running_sum;
    logic [15:0]      r_timeout_left,   n_timeout_left;
    logic [7:0]       r_retries_left,   n_retries_left;
    logic [7:0]       r_failure_count,  n_failure_count;

    logic [7:0] fail_inc;
    t_out_item  res;

    assign fail_inc = (r_failure_count != FAIL_SAT) ? r_failure_count + 8'd1
                                                     : r_failure_count;

    always_comb begin
        n_session_on     = r_session_on;
        n_in_packet      = r_in_packet;
        n_byte_pos       = r_byte_pos;
        n_expected_block = r_expected_block;
        n_block_seen     = r_block_seen;
        n_running_sum    = r_running_sum;
        n_timeout_left   = r_timeout_left;
        n_retries_left   = r_retries_left;
        n_failure_count  = r_failure_count;

        res.kind        = KIND_NONE;
        res.value       = 8'd0;
        res.commit      = 1'b0;
        res.session_end = 1'b0;
        res.handled     = r_session_on;

        if (i_item.cmd == CMD_START) begin
            // A restart keeps any open packet framing and the failure count.
            n_session_on     = 1'b1;
            n_timeout_left   = i_cfg.timeout_ticks;
            n_retries_left   = i_cfg.start_retries;
            n_expected_block = 8'd1;
        end else if (r_session_on && i_item.cmd == CMD_BYTE) begin
            if (r_in_packet) begin
                n_byte_pos = r_byte_pos + 1'b1;
                if (r_byte_pos == '0) begin
                    n_block_seen = i_item.rx_byte;
                end else if (r_byte_pos == POS_W'(1)) begin
                    // The complement byte is not checked.
                end else if (r_byte_pos < POS_CHECKSUM) begin
                    n_running_sum = r_running_sum + i_item.rx_byte;
                    res.kind      = KIND_PAYLOAD;
                    res.value     = i_item.rx_byte;
                end else begin
                    n_in_packet = 1'b0;
                    n_byte_pos  = '0;
                    res.kind    = KIND_REPLY;
                    if (r_block_seen == r_expected_block &&
                        r_running_sum == i_item.rx_byte) begin
                        n_expected_block = r_expected_block + 8'd1;
                        n_failure_count  = 8'd0;
                        res.value        = BYTE_ACK;
                        res.commit       = 1'b1;
                    end else begin
                        res.value = BYTE_NAK;
                    end
                end
            end else begin
                n_byte_pos = '0;
                if (i_item.rx_byte == BYTE_SOH) begin
                    n_in_packet    = 1'b1;
                    n_running_sum  = 8'd0;
                    n_timeout_left = i_cfg.timeout_ticks;
                    n_retries_left = i_cfg.packet_retries;
                end else if (i_item.rx_byte == BYTE_EOT || i_item.rx_byte == BYTE_CAN) begin
                    n_session_on     = 1'b0;
                    n_in_packet      = 1'b0;
                    n_byte_pos       = '0;
                    n_expected_block = 8'd0;
                    n_block_seen     = 8'd0;
                    n_running_sum    = 8'd0;
                    n_timeout_left   = 16'd0;
                    n_retries_left   = 8'd0;
                    n_failure_count  = 8'd0;
                    res.kind         = KIND_REPLY;
                    res.value        = BYTE_ACK;
                    res.session_end  = 1'b1;
                end
            end
        end else if (r_session_on && i_item.cmd == CMD_TICK) begin
            if (r_timeout_left != 16'd0) begin
                n_timeout_left = r_timeout_left - 16'd1;
            end else begin
                n_failure_count = fail_inc;
                res.kind        = KIND_REPLY;
                if (fail_inc >= i_cfg.max_failures) begin
                    // Too many failures in a row: abort and clear the session.
                    n_session_on     = 1'b0;
                    n_in_packet      = 1'b0;
                    n_byte_pos       = '0;
                    n_expected_block = 8'd0;
                    n_block_seen     = 8'd0;
                    n_running_sum    = 8'd0;
                    n_timeout_left   = 16'd0;
                    n_retries_left   = 8'd0;
                    n_failure_count  = 8'd0;
                    res.value        = BYTE_CAN;
                    res.session_end  = 1'b1;
                end else begin
                    res.value      = BYTE_NAK;
                    n_timeout_left = i_cfg.timeout_ticks;
                    if (r_retries_left != 8'd0) begin
                        n_retries_left = r_retries_left - 8'd1;
                    end else begin
                        // Out of retries: the session drops but keeps its failure count.
                        n_session_on    = 1'b0;
                        n_in_packet     = 1'b0;
                        n_byte_pos      = '0;
                        res.session_end = 1'b1;
                    end
                end
            end
        end

        res.active = n_session_on;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_session_on     <= 1'b0;
            r_in_packet      <= 1'b0;
            r_byte_pos       <= '0;
            r_expected_block <= 8'd0;
            r_block_seen     <= 8'd0;
            r_running_sum    <= 8'd0;
            r_timeout_left   <= 16'd0;
            r_retries_left   <= 8'd0;
            r_failure_count  <= 8'd0;
        end else if (i_step) begin
            r_session_on     <= n_session_on;
            r_in_packet      <= n_in_packet;
            r_byte_pos       <= n_byte_pos;
            r_expected_block <= n_expected_block;
            r_block_seen     <= n_block_seen;
            r_running_sum    <= n_running_sum;
            r_timeout_left   <= n_timeout_left;
            r_retries_left   <= n_retries_left;
            r_failure_count  <= n_failure_count;
        end
    end

    assign o_result = res;

    `XCR_ASSERT(a_packet_needs_session, r_in_packet |-> r_session_on)
    `XCR_ASSERT(a_idle_position_zero, !r_in_packet |-> r_byte_pos == '0)
    `XCR_ASSERT(a_commit_advances_block,
        i_step && res.commit |=> r_expected_block == $past(r_expected_block) + 8'd1)
    `XCR_ASSERT(a_position_in_frame, r_byte_pos <= POS_CHECKSUM)

endmodule

// ----- bench/xmodem_checksum_receiver_checker.sv -----
// Checker for the XMODEM checksum receiver: predicts every result and compares it on transfer.
`timescale 1ns / 100ps
module xmodem_checksum_receiver_checker
    import xcr_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_item    i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_item   i_out_data,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic [31:0] i_prdata,
    input  logic        i_pready,
    output int          o_failures,
    output int          o_awaited,
    output int          o_committed,
    output int          o_rejected,
    output int          o_aborted,
    output int          o_payload
);

    // Configuration as last written over APB.
    t_cfg        cfg;

    // Predicted protocol state.
    logic        link_up;
    logic        framing;
    logic [15:0] frame_pos;
    logic [7:0]  next_block;
    logic [7:0]  got_block;
    logic [7:0]  payload_sum;
    logic [15:0] ticks_left;
    logic [7:0]  retries;
    logic [7:0]  fail_run;

    t_out_item   awaited_results[$];
    int          results_seen;

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        o_failures++;
    endtask

    function automatic void clear_link();
        link_up     = 1'b0;
        framing     = 1'b0;
        frame_pos   = '0;
        next_block  = '0;
        got_block   = '0;
        payload_sum = '0;
        ticks_left  = '0;
        retries     = '0;
        fail_run    = '0;
    endfunction

    function automatic t_out_item receiver_result(input t_in_item it);
        t_out_item r;
        logic      was_up;
        r = '0;
        was_up = link_up;
        if (it.cmd == CMD_START) begin
            // Re-arming keeps any packet framing and the failure run.
            link_up    = 1'b1;
            ticks_left = cfg.timeout_ticks;
            retries    = cfg.start_retries;
            next_block = 8'd1;
        end else if (was_up && it.cmd == CMD_BYTE && framing) begin
            if (frame_pos == 16'(PAYLOAD_BYTES + 2)) begin
                framing   = 1'b0;
                frame_pos = '0;
                r.kind    = KIND_REPLY;
                if (got_block == next_block && payload_sum == it.rx_byte) begin
                    next_block++;
                    fail_run = '0;
                    r.value  = BYTE_ACK;
                    r.commit = 1'b1;
                end else begin
                    r.value = BYTE_NAK;
                end
            end else begin
                // Position 1 is the complement, which is not checked.
                if (frame_pos == 0) begin
                    got_block = it.rx_byte;
                end else if (frame_pos >= 2) begin
                    payload_sum += it.rx_byte;
                    r.kind  = KIND_PAYLOAD;
                    r.value = it.rx_byte;
                end
                frame_pos++;
            end
        end else if (was_up && it.cmd == CMD_BYTE) begin
            frame_pos = '0;
            if (it.rx_byte == BYTE_SOH) begin
                framing     = 1'b1;
                payload_sum = '0;
                ticks_left  = cfg.timeout_ticks;
                retries     = cfg.packet_retries;
            end else if (it.rx_byte == BYTE_EOT || it.rx_byte == BYTE_CAN) begin
                clear_link();
                r.kind        = KIND_REPLY;
                r.value       = BYTE_ACK;
                r.session_end = 1'b1;
            end
        end else if (was_up && it.cmd == CMD_TICK) begin
            if (ticks_left != 0) begin
                ticks_left--;
            end else begin
                if (fail_run != FAIL_SAT) begin
                    fail_run++;
                end
                r.kind = KIND_REPLY;
                if (fail_run >= cfg.max_failures) begin
                    clear_link();
                    r.value       = BYTE_CAN;
                    r.session_end = 1'b1;
                end else begin
                    r.value    = BYTE_NAK;
                    ticks_left = cfg.timeout_ticks;
                    if (retries != 0) begin
                        retries--;
                    end else begin
                        // Out of retries: the session drops but the failure run is kept.
                        link_up       = 1'b0;
                        framing       = 1'b0;
                        frame_pos     = '0;
                        r.session_end = 1'b1;
                    end
                end
            end
        end
        r.handled = was_up;
        r.active  = link_up;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item   want;
        logic [31:0] reg_now;
        if (!i_rst_n) begin
            clear_link();
            cfg = {TIMEOUT_TICKS_RST, START_RETRIES_RST, PACKET_RETRIES_RST, MAX_FAILURES_RST};
            awaited_results.delete();
            results_seen = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    flag_mismatch($sformatf("result %0d transferred with none awaited",
                                            results_seen));
                end else begin
                    want = awaited_results.pop_front();
                    if (i_out_data.kind !== want.kind)
                        flag_mismatch($sformatf("result %0d kind %0d, expected %0d",
                                                results_seen, i_out_data.kind, want.kind));
                    if (i_out_data.value !== want.value)
                        flag_mismatch($sformatf("result %0d value %h, expected %h",
                                                results_seen, i_out_data.value, want.value));
                    if (i_out_data.commit !== want.commit)
                        flag_mismatch($sformatf("result %0d commit %b, expected %b",
                                                results_seen, i_out_data.commit, want.commit));
                    if (i_out_data.session_end !== want.session_end)
                        flag_mismatch($sformatf("result %0d session_end %b, expected %b",
                                                results_seen, i_out_data.session_end,
                                                want.session_end));
                    if (i_out_data.handled !== want.handled)
                        flag_mismatch($sformatf("result %0d handled %b, expected %b",
                                                results_seen, i_out_data.handled, want.handled));
                    if (i_out_data.active !== want.active)
                        flag_mismatch($sformatf("result %0d active %b, expected %b",
                                                results_seen, i_out_data.active, want.active));
                    if (want.kind == KIND_PAYLOAD) begin
                        o_payload++;
                    end else if (want.kind == KIND_REPLY && want.commit) begin
                        o_committed++;
                    end else if (want.kind == KIND_REPLY && want.value == BYTE_NAK) begin
                        o_rejected++;
                    end else if (want.kind == KIND_REPLY && want.value == BYTE_CAN) begin
                        o_aborted++;
                    end
                end
                results_seen++;
            end
            if (i_in_valid && i_in_ready) begin
                awaited_results.push_back(receiver_result(i_in_data));
            end
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    case (i_paddr[3:2])
                        REG_TIMEOUT_TICKS:  cfg.timeout_ticks  = i_pwdata[15:0];
                        REG_START_RETRIES:  cfg.start_retries  = i_pwdata[7:0];
                        REG_PACKET_RETRIES: cfg.packet_retries = i_pwdata[7:0];
                        default:            cfg.max_failures   = i_pwdata[7:0];
                    endcase
                end else begin
                    case (i_paddr[3:2])
                        REG_TIMEOUT_TICKS:  reg_now = {16'd0, cfg.timeout_ticks};
                        REG_START_RETRIES:  reg_now = {24'd0, cfg.start_retries};
                        REG_PACKET_RETRIES: reg_now = {24'd0, cfg.packet_retries};
                        default:            reg_now = {24'd0, cfg.max_failures};
                    endcase
                    if (i_prdata !== reg_now)
                        flag_mismatch($sformatf("register at %h reads %h, expected %h",
                                                i_paddr, i_prdata, reg_now));
                end
            end
        end
        o_awaited = awaited_results.size();
    end

endmodule

// ----- bench/tb_xmodem_checksum_receiver_unit.sv -----
// Testbench top for the XMODEM checksum receiver: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_xmodem_checksum_receiver_unit;
    import xcr_pkg::*;

    localparam int         PAYLOAD_BYTES  = PAYLOAD_BYTES_DEF;
    localparam logic [1:0] CMD_UNUSED     = 2'd3;
    localparam int         PHASE_ITEMS    = 212;
    localparam int         LONG_HOLD      = 300;
    localparam int         SETTLE_CYCLES  = 4;
    localparam int         WATCHDOG_LIMIT = 5000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    t_in_item    in_data;
    logic        out_valid;
    logic        out_ready;
    t_out_item   out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          failures;
    int          awaited;
    int          committed;
    int          rejected;
    int          aborted;
    int          payload;

    int          items_sent;
    int          sender_idle_pct;
    int          recv_stall_pct;
    int          holds_asked;
    int          holds_done;
    int          quiet_cycles;

    // Rough guess of the session state, used to build packets that should be accepted.
    logic        link_on;
    logic [7:0]  link_block;

    xmodem_checksum_receiver_unit #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    xmodem_checksum_receiver_checker #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) i_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_ready (in_ready),
        .i_in_data  (in_data),
        .i_out_valid(out_valid),
        .i_out_ready(out_ready),
        .i_out_data (out_data),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .i_prdata   (prdata),
        .i_pready   (pready),
        .o_failures (failures),
        .o_awaited  (awaited),
        .o_committed(committed),
        .o_rejected (rejected),
        .o_aborted  (aborted),
        .o_payload  (payload)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Result side: random stalls, plus long hold-offs on request.
    initial begin
        out_ready  = 1'b0;
        holds_done = 0;
        forever begin
            @(negedge clk);
            if (holds_done != holds_asked) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                holds_done++;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("xmodem_checksum_receiver_unit test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [7:0] any_byte();
        case ($urandom_range(9))
            0:       return BYTE_SOH;
            1:       return BYTE_EOT;
            2:       return BYTE_CAN;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= {op, b};
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(CMD_TICK, 8'($urandom_range(255)));
    endtask

    task automatic send_start();
        send_item(CMD_START, 8'($urandom_range(255)));
        link_on    = 1'b1;
        link_block = 8'd1;
    endtask

    // A cut_after of -1 sends the whole packet; otherwise it stops after that many bytes.
    task automatic send_packet(input logic right_block, input logic right_sum,
                               input int cut_after);
        logic [7:0] blk;
        logic [7:0] sum;
        logic [7:0] b;
        blk = right_block ? link_block : 8'($urandom_range(255));
        sum = '0;
        send_item(CMD_BYTE, BYTE_SOH);
        for (int i = 0; i < PAYLOAD_BYTES + 3 && i != cut_after; i++) begin
            if ($urandom_range(99) < 3) begin
                send_tick();
            end
            if (i == 0) begin
                b = blk;
            end else if (i == 1) begin
                b = ~blk;
            end else if (i < PAYLOAD_BYTES + 2) begin
                b = any_byte();
                sum = sum + b;
            end else begin
                b = right_sum ? sum : sum + 8'($urandom_range(1, 255));
            end
            send_item(CMD_BYTE, b);
        end
        if (right_block && right_sum && cut_after < 0) begin
            link_block++;
        end
    endtask

    task automatic random_traffic(input int n);
        int stop_at;
        int pick;
        int r;
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            // A full packet is only started while it still fits in the item budget.
            if (pick < 40 && stop_at - items_sent > PAYLOAD_BYTES + 12) begin
                // Mostly well-formed packets; some carry a wrong block number or checksum.
                if (!link_on) begin
                    send_start();
                end
                r = $urandom_range(9);
                send_packet(r != 0, r > 2, -1);
            end else if (pick < 48) begin
                send_start();
            end else if (pick < 63) begin
                repeat ($urandom_range(1, 6)) send_tick();
            end else if (pick < 71) begin
                send_item(CMD_BYTE, (pick < 67) ? BYTE_EOT : BYTE_CAN);
                link_on = 1'b0;
            end else if (pick < 88) begin
                repeat ($urandom_range(1, 4)) send_item(2'($urandom_range(3)), any_byte());
            end else begin
                send_packet(1'b1, 1'b1, $urandom_range(0, 20));
            end
        end
    endtask

    // Stops offering items and waits until every result has come back.
    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic read_back_all();
        apb_access(1'b0, REG_TIMEOUT_TICKS, '0);
        apb_access(1'b0, REG_START_RETRIES, '0);
        apb_access(1'b0, REG_PACKET_RETRIES, '0);
        apb_access(1'b0, REG_MAX_FAILURES, '0);
    endtask

    task automatic start_phase(input t_cfg c, input int send_pct, input int stall_pct);
        wait_for_results();
        apb_access(1'b1, REG_TIMEOUT_TICKS, {16'd0, c.timeout_ticks});
        apb_access(1'b1, REG_START_RETRIES, {24'd0, c.start_retries});
        apb_access(1'b1, REG_PACKET_RETRIES, {24'd0, c.packet_retries});
        apb_access(1'b1, REG_MAX_FAILURES, {24'd0, c.max_failures});
        read_back_all();
        sender_idle_pct = send_pct;
        recv_stall_pct  = stall_pct;
        link_on         = 1'b0;
    endtask

    initial begin
        t_cfg mixed;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        in_data         = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        items_sent      = 0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        holds_asked     = 0;
        link_on         = 1'b0;
        link_block      = 8'd1;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        read_back_all();

        // Nothing happens without a session, whatever the command; then sessions end on EOT and CAN.
        send_item(CMD_BYTE, BYTE_SOH);
        send_tick();
        send_item(CMD_UNUSED, 8'hFF);
        send_start();
        send_item(CMD_BYTE, 8'h55);
        send_tick();
        send_item(CMD_UNUSED, 8'h00);
        send_item(CMD_BYTE, BYTE_EOT);
        send_start();
        send_item(CMD_BYTE, BYTE_CAN);
        // A start in the middle of a packet keeps the framing going.
        send_start();
        send_item(CMD_BYTE, BYTE_SOH);
        send_item(CMD_BYTE, 8'h00);
        send_start();
        send_item(CMD_BYTE, 8'hFF);
        send_item(CMD_BYTE, 8'hFF);
        send_item(CMD_BYTE, BYTE_EOT);

        // Immediate timeouts: a NAK, a drop on exhausted retries, then a CAN abort.
        start_phase(t_cfg'{16'd0, 8'd1, 8'd0, 8'd3}, 0, 0);
        send_start();
        send_tick();
        send_tick();
        send_start();
        send_tick();

        // With no failures allowed every timeout aborts.
        wait_for_results();
        apb_access(1'b1, REG_MAX_FAILURES, 32'd0);
        apb_access(1'b0, REG_MAX_FAILURES, '0);
        send_start();
        send_tick();

        // The result side holds off while items keep coming, so the input backs up.
        start_phase(t_cfg'{16'd65535, 8'd255, 8'd255, 8'd255}, 0, 0);
        holds_asked++;
        random_traffic(PHASE_ITEMS);

        start_phase(t_cfg'{16'd2, 8'd3, 8'd1, 8'd4}, 73, 0);
        random_traffic(PHASE_ITEMS);

        start_phase(t_cfg'{16'd0, 8'd0, 8'd0, 8'd1}, 0, 73);
        random_traffic(PHASE_ITEMS / 2);
        wait_for_results();
        random_traffic(PHASE_ITEMS - PHASE_ITEMS / 2);

        mixed.timeout_ticks  = 16'($urandom_range(6));
        mixed.start_retries  = 8'($urandom_range(8));
        mixed.packet_retries = 8'($urandom_range(4));
        mixed.max_failures   = 8'($urandom_range(1, 6));
        start_phase(mixed, 23, 23);
        random_traffic(PHASE_ITEMS);

        wait_for_results();
        $display("Run summary: %0d items over four idle patterns and seven register settings.",
                 items_sent);
        $display("Results: %0d packets committed, %0d NAKs, %0d CAN aborts, %0d payload bytes.",
                 committed, rejected, aborted, payload);
        if (failures == 0) begin
            $display("xmodem_checksum_receiver_unit test passed");
        end else begin
            $display("xmodem_checksum_receiver_unit test failed");
        end
        $finish;
    end

endmodule

// ----- xmodem_checksum_receiver_unit.f -----
+incdir+hw/rtl
hw/rtl/xcr_pkg.sv
hw/rtl/xcr_regs.sv
hw/rtl/xcr_core.sv
hw/rtl/xmodem_checksum_receiver_unit.sv
bench/xmodem_checksum_receiver_checker.sv
bench/tb_xmodem_checksum_receiver_unit.sv
